### rtl/mcba_pkg.sv
// ----------------------------------------------------------------------------
// mcba_pkg
// Shared widths, codes and table entry type of the mark-compact allocator.
// ----------------------------------------------------------------------------
package mcba_pkg;

   localparam int SIZE_W   = 26;
   localparam int ADDR_W   = 25;
   localparam int FP_W     = 27;
   localparam int OP_W     = 2;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int LIVE_W   = 6;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 112;

   localparam int MAX_OBJECTS_DEF = 32;

   localparam logic [SIZE_W-1:0] HEAP_LIMIT = 26'h200_0000;

   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_MARK    = 2'd1;
   localparam logic [OP_W-1:0] OP_COLLECT = 2'd2;

   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MARK  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE  = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_TOO_LARGE  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd3;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 3'd4;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [SIZE_W-1:0] len;
   } entry_type;

endpackage

### rtl/mark_compact_bump_allocator_core.sv
// ----------------------------------------------------------------------------
// mark_compact_bump_allocator_core
// Bump-pointer heap allocator with sliding mark-compact collection.
//
//   channel | ports  | direction | carries
//   --------+--------+-----------+------------------------------------------
//   request | req_*  | in        | op, object_bytes, object_address
//   result  | rsp_*  | out       | kind, status, addresses, length, totals
//   csr     | csr_*  | in        | heap_size
//
// An allocation that fits is written to the table in the check state. Mark
// compares one table entry per cycle. Compaction walks the table
// twice through its single read port.
// A stalled result holds the walk. Reset is synchronous and clears the
// bump pointer, entry count and marks; the table itself needs no clearing.
// ----------------------------------------------------------------------------
module mark_compact_bump_allocator_core #(
   parameter int MAX_OBJECTS = mcba_pkg::MAX_OBJECTS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [mcba_pkg::SIZE_W-1:0]       csr_wr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // object_bytes[25:0], object_address[50:26], zero pad
   input  logic [mcba_pkg::REQ_DATA_W-1:0]   req_tdata,
   // op
   input  logic [mcba_pkg::OP_W-1:0]         req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status[2:0], target_address[27:3], source_address[52:28],
   // move_length[78:53], live_objects[84:79], used_bytes[110:85], zero pad
   output logic [mcba_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // kind
   output logic [mcba_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                              rsp_tlast
);
   import mcba_pkg::*;

   localparam int IW = $clog2(MAX_OBJECTS);
   localparam int CW = $clog2(MAX_OBJECTS + 1);
   localparam logic [CW-1:0] MAX_CNT = CW'(MAX_OBJECTS);

   typedef enum logic [6:0] {
      S_IDLE   = 7'b0000001,
      S_CHECK  = 7'b0000010,
      S_SCAN   = 7'b0000100,
      S_PLAN   = 7'b0001000,
      S_MOVE   = 7'b0010000,
      S_SEARCH = 7'b0100000,
      S_ANSWER = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   target;
      logic [ADDR_W-1:0]   source;
      logic [SIZE_W-1:0]   len;
      logic [LIVE_W-1:0]   live;
      logic [SIZE_W-1:0]   used;
      logic                last;
   } rsp_type;

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   heap_ff;
   logic [SIZE_W-1:0]   nf_ff, nf_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [MAX_OBJECTS-1:0] marks_ff, marks_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [FP_W-1:0]     fp_ff, fp_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       keep_ff, keep_in;
   logic [SIZE_W-1:0]   acc_ff, acc_in;
   logic [KIND_W-1:0]   ans_kind_ff, ans_kind_in;
   logic [STATUS_W-1:0] ans_status_ff, ans_status_in;
   logic [ADDR_W-1:0]   ans_target_ff, ans_target_in;
   logic                alloc_ok_ff, alloc_ok_in;
   logic [CW-1:0]       fin_count_ff, fin_count_in;
   logic [SIZE_W-1:0]   fin_nf_ff, fin_nf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic [SIZE_W-1:0]   lim;
   logic [SIZE_W-1:0]   room;
   logic [SIZE_W-1:0]   room_after;
   logic [CW-1:0]       idx_nx;
   logic                slot_free;
   logic                cur_mark;
   logic                need_move;
   logic [SIZE_W-1:0]   acc_sum;

   logic                mem_we;
   logic [IW-1:0]       mem_waddr;
   entry_type           mem_wdata;
   logic [IW-1:0]       mem_raddr;
   entry_type           rd;

   mcba_table #(
      .DEPTH (MAX_OBJECTS),
      .IW    (IW)
   ) u_table (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (mem_waddr),
      .wr_entry (mem_wdata),
      .rd_addr  (mem_raddr),
      .rd_entry (rd)
   );

   assign lim        = (heap_ff > HEAP_LIMIT) ? HEAP_LIMIT : heap_ff;
   assign room       = (lim > nf_ff) ? (lim - nf_ff) : '0;
   assign room_after = (lim > acc_ff) ? (lim - acc_ff) : '0;
   assign idx_nx     = idx_ff + 1'b1;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign cur_mark   = marks_ff[idx_ff[IW-1:0]];
   assign need_move  = {1'b0, rd.base} != acc_ff;
   assign acc_sum    = acc_ff + rd.len;

   always_comb begin
      state_in      = state_ff;
      nf_in         = nf_ff;
      count_in      = count_ff;
      marks_in      = marks_ff;
      op_in         = op_ff;
      fp_in         = fp_ff;
      addr_in       = addr_ff;
      idx_in        = idx_ff;
      keep_in       = keep_ff;
      acc_in        = acc_ff;
      ans_kind_in   = ans_kind_ff;
      ans_status_in = ans_status_ff;
      ans_target_in = ans_target_ff;
      alloc_ok_in   = alloc_ok_ff;
      fin_count_in  = fin_count_ff;
      fin_nf_in     = fin_nf_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = keep_ff[IW-1:0];
      mem_wdata     = '{base: acc_ff[ADDR_W-1:0], len: rd.len};
      mem_raddr     = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in   = req_tuser;
               fp_in   = {1'b0, req_tdata[SIZE_W-1:0]} + 1'b1;
               addr_in = req_tdata[SIZE_W+ADDR_W-1:SIZE_W];
               if (req_tuser == OP_ALLOC || req_tuser == OP_MARK ||
                   req_tuser == OP_COLLECT) begin
                  state_in = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            idx_in       = '0;
            keep_in      = '0;
            acc_in       = '0;
            fin_count_in = count_ff;
            fin_nf_in    = nf_ff;
            alloc_ok_in  = 1'b0;
            ans_target_in = '0;
            ans_status_in = ST_OK;
            case (op_ff)
               OP_ALLOC: begin
                  ans_kind_in = KIND_ALLOC;
                  if (fp_ff > {1'b0, lim}) begin
                     ans_status_in = ST_TOO_LARGE;
                     state_in      = S_ANSWER;
                  end else if (fp_ff > {1'b0, room} || count_ff >= MAX_CNT) begin
                     state_in = S_SCAN;
                  end else begin
                     mem_we        = 1'b1;
                     mem_waddr     = count_ff[IW-1:0];
                     mem_wdata     = '{base: nf_ff[ADDR_W-1:0], len: fp_ff[SIZE_W-1:0]};
                     count_in      = count_ff + 1'b1;
                     nf_in         = nf_ff + fp_ff[SIZE_W-1:0];
                     fin_count_in  = count_ff + 1'b1;
                     fin_nf_in     = nf_ff + fp_ff[SIZE_W-1:0];
                     ans_target_in = nf_ff[ADDR_W-1:0];
                     state_in      = S_ANSWER;
                  end
               end
               OP_MARK: begin
                  ans_kind_in = KIND_MARK;
                  state_in    = S_SEARCH;
               end
               OP_COLLECT: begin
                  ans_kind_in = KIND_DONE;
                  state_in    = S_SCAN;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            mem_raddr = idx_nx[IW-1:0];
            if (idx_ff == count_ff) begin
               state_in = S_PLAN;
            end else begin
               if (cur_mark) begin
                  acc_in  = acc_sum;
                  keep_in = keep_ff + 1'b1;
               end
               idx_in = idx_nx;
            end
         end
         S_PLAN: begin
            fin_count_in  = keep_ff;
            fin_nf_in     = acc_ff;
            alloc_ok_in   = 1'b0;
            ans_target_in = '0;
            ans_status_in = ST_OK;
            if (op_ff == OP_ALLOC) begin
               if (fp_ff > {1'b0, room_after}) begin
                  ans_status_in = ST_NO_SPACE;
               end else if (keep_ff >= MAX_CNT) begin
                  ans_status_in = ST_TABLE_FULL;
               end else begin
                  alloc_ok_in   = 1'b1;
                  ans_target_in = acc_ff[ADDR_W-1:0];
                  fin_count_in  = keep_ff + 1'b1;
                  fin_nf_in     = acc_ff + fp_ff[SIZE_W-1:0];
               end
            end
            idx_in   = '0;
            keep_in  = '0;
            acc_in   = '0;
            state_in = S_MOVE;
         end
         S_MOVE: begin
            mem_raddr = idx_ff[IW-1:0];
            if (idx_ff == count_ff) begin
               marks_in = '0;
               count_in = fin_count_ff;
               nf_in    = fin_nf_ff;
               if (alloc_ok_ff) begin
                  mem_we    = 1'b1;
                  mem_wdata = '{base: acc_ff[ADDR_W-1:0], len: fp_ff[SIZE_W-1:0]};
               end
               state_in = S_ANSWER;
            end else if (!cur_mark) begin
               mem_raddr = idx_nx[IW-1:0];
               idx_in    = idx_nx;
            end else if (!need_move || slot_free) begin
               if (need_move) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{kind: KIND_MOVE, status: ST_OK,
                                   target: acc_ff[ADDR_W-1:0], source: rd.base,
                                   len: rd.len, live: LIVE_W'(fin_count_ff),
                                   used: fin_nf_ff, last: 1'b0};
               end
               mem_we    = 1'b1;
               acc_in    = acc_sum;
               keep_in   = keep_ff + 1'b1;
               mem_raddr = idx_nx[IW-1:0];
               idx_in    = idx_nx;
            end
         end
         S_SEARCH: begin
            mem_raddr = idx_nx[IW-1:0];
            if (idx_ff == count_ff) begin
               ans_status_in = ST_NOT_FOUND;
               state_in      = S_ANSWER;
            end else if (rd.base == addr_ff) begin
               marks_in[idx_ff[IW-1:0]] = 1'b1;
               state_in = S_ANSWER;
            end else begin
               idx_in = idx_nx;
            end
         end
         S_ANSWER: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{kind: ans_kind_ff, status: ans_status_ff,
                                target: ans_target_ff, source: '0, len: '0,
                                live: LIVE_W'(fin_count_ff), used: fin_nf_ff,
                                last: 1'b1};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         heap_ff      <= HEAP_LIMIT;
         nf_ff        <= '0;
         count_ff     <= '0;
         marks_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nf_ff        <= nf_in;
         count_ff     <= count_in;
         marks_ff     <= marks_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            heap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      fp_ff         <= fp_in;
      addr_ff       <= addr_in;
      idx_ff        <= idx_in;
      keep_ff       <= keep_in;
      acc_ff        <= acc_in;
      ans_kind_ff   <= ans_kind_in;
      ans_status_ff <= ans_status_in;
      ans_target_ff <= ans_target_in;
      alloc_ok_ff   <= alloc_ok_in;
      fin_count_ff  <= fin_count_in;
      fin_nf_ff     <= fin_nf_in;
      rsp_ff        <= rsp_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {1'b0, rsp_ff.used, rsp_ff.live, rsp_ff.len, rsp_ff.source,
                        rsp_ff.target, rsp_ff.status};

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_CNT)
      else $error("entry count above table depth");

   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      nf_ff <= HEAP_LIMIT)
      else $error("bump pointer beyond heap limit");

   a_keep_behind: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) |-> (keep_ff <= idx_ff))
      else $error("compaction write index overtook read index");

   a_move_left: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_MOVE) |->
         (rsp_ff.target < rsp_ff.source && !rsp_ff.last && rsp_ff.len != '0))
      else $error("move command does not slide left");
`endif

endmodule

### rtl/mcba_table.sv
// ----------------------------------------------------------------------------
// mcba_table
// Object table: base and footprint per entry, one write and one registered
// read port.
// ----------------------------------------------------------------------------
module mcba_table #(
   parameter int DEPTH = mcba_pkg::MAX_OBJECTS_DEF,
   parameter int IW    = $clog2(mcba_pkg::MAX_OBJECTS_DEF)
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IW-1:0]       wr_addr,
   input  mcba_pkg::entry_type wr_entry,
   input  logic [IW-1:0]       rd_addr,
   output mcba_pkg::entry_type rd_entry
);
   import mcba_pkg::*;

   entry_type mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      rd_entry <= mem[rd_addr];
   end

endmodule

### tb/sv/tb_mark_compact_bump_allocator_core.sv
// ----------------------------------------------------------------------------
// tb_mark_compact_bump_allocator_core
// Self-checking bench for the mark-compact bump allocator. A request queue
// feeds a bursty stream driver; a shadow allocator predicts the results of
// every accepted request (answers, slide moves, totals). A stalling result
// monitor compares them field by field. Several heap sizes are exercised,
// from one byte to beyond the clamp, with directed corners, a full table
// and random alloc/mark/collect rounds.
// ----------------------------------------------------------------------------
module tb_mark_compact_bump_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import mcba_pkg::*;

   localparam int N_OBJ = MAX_OBJECTS_DEF;
   localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
   localparam int SETTLE_CYCLES = 4 * N_OBJ + 40;
   localparam logic [SIZE_W-1:0] SIZE_ALL_ONES = '1;
   localparam logic [ADDR_W-1:0] ADDR_ALL_ONES = '1;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [SIZE_W-1:0] bytes;
      logic [ADDR_W-1:0] addr;
   } heap_request_t;

   typedef struct {
      logic [KIND_W-1:0]   kind;
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   target;
      logic [ADDR_W-1:0]   source;
      logic [SIZE_W-1:0]   length;
      logic [LIVE_W-1:0]   live;
      logic [SIZE_W-1:0]   used;
      logic                last;
   } heap_result_t;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [SIZE_W-1:0]     csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [OP_W-1:0]       req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;

   mark_compact_bump_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("tb_mark_compact_bump_allocator_core failed");
      $finish;
   end

   // shadow allocator
   logic [SIZE_W-1:0] heap_reg = HEAP_LIMIT;
   logic [FP_W-1:0]   bump_ptr = '0;
   int                obj_count = 0;
   logic [ADDR_W-1:0] obj_base [N_OBJ];
   logic [FP_W-1:0]   obj_len [N_OBJ];
   bit                obj_marked [N_OBJ];
   heap_result_t      step_results [$];
   heap_result_t      heap_results [$];

   heap_request_t     request_queue [$];
   heap_request_t     in_flight;
   int                burst_left = 0;
   int                gap_left = 0;
   int                fault_count = 0;
   logic [31:0]       ready_pattern = '1;
   int                pattern_left = 0;

   function automatic logic [FP_W-1:0] heap_bound();
      return (heap_reg > HEAP_LIMIT) ? FP_W'(HEAP_LIMIT) : FP_W'(heap_reg);
   endfunction

   function automatic logic [FP_W-1:0] heap_room();
      return (bump_ptr >= heap_bound()) ? '0 : heap_bound() - bump_ptr;
   endfunction

   function automatic heap_result_t answer(logic [KIND_W-1:0] kind,
                                           logic [STATUS_W-1:0] status,
                                           logic [ADDR_W-1:0] target);
      heap_result_t r;
      r = '{default: '0};
      r.kind = kind;
      r.status = status;
      r.target = target;
      return r;
   endfunction

   task automatic slide_marked();
      logic [FP_W-1:0] dest;
      int keep;
      heap_result_t r;
      dest = '0;
      keep = 0;
      for (int i = 0; i < obj_count; i++) begin
         if (obj_marked[i]) begin
            if (FP_W'(obj_base[i]) != dest) begin
               r = answer(KIND_MOVE, ST_OK, dest[ADDR_W-1:0]);
               r.source = obj_base[i];
               r.length = obj_len[i][SIZE_W-1:0];
               step_results.push_back(r);
            end
            obj_base[keep] = dest[ADDR_W-1:0];
            obj_len[keep] = obj_len[i];
            obj_marked[keep] = 1'b0;
            dest += obj_len[i];
            keep++;
         end
      end
      for (int i = keep; i < N_OBJ; i++) obj_marked[i] = 1'b0;
      obj_count = keep;
      bump_ptr = dest;
   endtask

   task automatic heap_step(input heap_request_t rq);
      logic [FP_W-1:0] fp;
      bit found;
      heap_result_t r;
      step_results.delete();
      case (rq.op)
         OP_ALLOC: begin
            fp = FP_W'(rq.bytes) + 1'b1;
            if (fp > heap_bound()) begin
               step_results.push_back(answer(KIND_ALLOC, ST_TOO_LARGE, '0));
            end else begin
               if (fp > heap_room() || obj_count >= N_OBJ) slide_marked();
               if (fp > heap_room()) begin
                  step_results.push_back(answer(KIND_ALLOC, ST_NO_SPACE, '0));
               end else if (obj_count >= N_OBJ) begin
                  step_results.push_back(answer(KIND_ALLOC, ST_TABLE_FULL, '0));
               end else begin
                  obj_base[obj_count] = bump_ptr[ADDR_W-1:0];
                  obj_len[obj_count] = fp;
                  obj_marked[obj_count] = 1'b0;
                  obj_count++;
                  step_results.push_back(answer(KIND_ALLOC, ST_OK, bump_ptr[ADDR_W-1:0]));
                  bump_ptr += fp;
               end
            end
         end
         OP_MARK: begin
            found = 1'b0;
            for (int i = 0; i < obj_count; i++) begin
               if (!found && obj_base[i] == rq.addr) begin
                  obj_marked[i] = 1'b1;
                  found = 1'b1;
               end
            end
            step_results.push_back(answer(KIND_MARK, found ? ST_OK : ST_NOT_FOUND, '0));
         end
         OP_COLLECT: begin
            slide_marked();
            step_results.push_back(answer(KIND_DONE, ST_OK, '0));
         end
         default: ;
      endcase
      foreach (step_results[j]) begin
         r = step_results[j];
         r.live = obj_count[LIVE_W-1:0];
         r.used = bump_ptr[SIZE_W-1:0];
         r.last = (j == step_results.size() - 1);
         heap_results.push_back(r);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) heap_step(in_flight);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || request_queue.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               in_flight = request_queue.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {{(REQ_DATA_W-ADDR_W-SIZE_W){1'b0}}, in_flight.addr, in_flight.bytes};
               req_tuser <= in_flight.op;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 12);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
   end

   function automatic void check_field(string name, longint unsigned want,
                                       longint unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endfunction

   task automatic check_result();
      heap_result_t want;
      if (heap_results.size() == 0) begin
         $error("result with no request outstanding: kind %0d", rsp_tuser);
         fault_count++;
      end else begin
         want = heap_results.pop_front();
         check_field("kind", want.kind, rsp_tuser);
         check_field("status", want.status, rsp_tdata[2:0]);
         check_field("target_address", want.target, rsp_tdata[27:3]);
         check_field("source_address", want.source, rsp_tdata[52:28]);
         check_field("move_length", want.length, rsp_tdata[78:53]);
         check_field("live_objects", want.live, rsp_tdata[84:79]);
         check_field("used_bytes", want.used, rsp_tdata[110:85]);
         check_field("last", want.last, rsp_tlast);
      end
   endtask

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (pattern_left == 0) begin
            pattern_left = 32;
            case ($urandom_range(0, 3))
               0: ready_pattern = '1;
               1: ready_pattern = $urandom;
               default: ready_pattern = $urandom | $urandom;
            endcase
         end
         rsp_tready <= ready_pattern[0];
         ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
         pattern_left--;
      end
   end

   function automatic bit heap_idle();
      return request_queue.size() == 0 && !req_tvalid && heap_results.size() == 0;
   endfunction

   task automatic wait_idle();
      while (!heap_idle()) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic drain_requests();
      while (request_queue.size() != 0) @(posedge clock);
   endtask

   task automatic push_request(logic [OP_W-1:0] op, logic [SIZE_W-1:0] bytes,
                               logic [ADDR_W-1:0] addr);
      heap_request_t rq;
      rq.op = op;
      rq.bytes = bytes;
      rq.addr = addr;
      request_queue.push_back(rq);
   endtask

   task automatic write_heap_size(logic [SIZE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      heap_reg = value;
   endtask

   function automatic logic [SIZE_W-1:0] random_bytes();
      logic [FP_W-1:0] bound;
      bound = heap_bound();
      case ($urandom_range(0, 9))
         7, 8: return SIZE_W'($urandom_range(0, int'(bound)));
         9: return SIZE_W'($urandom);
         default: return SIZE_W'($urandom_range(0, int'(bound / 8)));
      endcase
   endfunction

   // fill the table, mark everything and run into a full table
   task automatic fill_table();
      push_request(OP_COLLECT, '0, '0);
      push_request(OP_COLLECT, '0, '0);
      repeat (N_OBJ) push_request(OP_ALLOC, SIZE_W'($urandom_range(0, 3)), '0);
      wait_idle();
      for (int i = 0; i < obj_count; i++) push_request(OP_MARK, '0, obj_base[i]);
      push_request(OP_ALLOC, '0, '0);
      push_request(OP_COLLECT, '0, '0);
      push_request(OP_ALLOC, SIZE_W'($urandom_range(0, 3)), '0);
   endtask

   task automatic random_phase(int count);
      int made;
      logic [OP_W-1:0] op;
      made = 0;
      while (made < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               repeat ($urandom_range(1, 6)) begin
                  push_request(OP_ALLOC, random_bytes(), '0);
                  made++;
               end
               drain_requests();
               for (int i = 0; i < obj_count; i++) begin
                  if ($urandom_range(0, 2) != 0) begin
                     push_request(OP_MARK, '0, obj_base[i]);
                     made++;
                  end
               end
               if ($urandom_range(0, 2) == 0) begin
                  push_request(OP_COLLECT, '0, '0);
                  made++;
               end
            end
            6, 7: begin
               op = OP_W'($urandom_range(0, 3));
               push_request(op, SIZE_W'($urandom), ADDR_W'($urandom));
               if (op != OP_IGNORED) made++;
            end
            default: begin
               if ($urandom_range(0, 1) == 0) push_request(OP_MARK, '0, ADDR_W'($urandom));
               else push_request(OP_COLLECT, '0, '0);
               made++;
            end
         endcase
      end
   endtask

   initial begin
      logic [SIZE_W-1:0] heap_plan [6];
      heap_plan = '{SIZE_W'(1), SIZE_W'(100), SIZE_ALL_ONES, SIZE_W'(300),
                    SIZE_W'(1000), HEAP_LIMIT};
      for (int i = 0; i < N_OBJ; i++) begin
         obj_base[i] = '0;
         obj_len[i] = '0;
         obj_marked[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      push_request(OP_ALLOC, '0, '0);
      push_request(OP_ALLOC, SIZE_ALL_ONES, '0);
      push_request(OP_ALLOC, SIZE_W'(HEAP_LIMIT), '0);
      push_request(OP_MARK, '0, '0);
      push_request(OP_MARK, '0, '0);
      push_request(OP_MARK, '0, ADDR_ALL_ONES);
      push_request(OP_ALLOC, SIZE_W'(99), '0);
      push_request(OP_ALLOC, SIZE_W'(9), '0);
      push_request(OP_MARK, '0, ADDR_W'(101));
      push_request(OP_COLLECT, '0, '0);
      push_request(OP_ALLOC, HEAP_LIMIT - 1'b1, '0);
      push_request(OP_MARK, '0, '0);
      push_request(OP_ALLOC, SIZE_W'(5), '0);
      push_request(OP_COLLECT, '0, '0);
      push_request(OP_IGNORED, SIZE_ALL_ONES, ADDR_ALL_ONES);
      push_request(OP_COLLECT, '0, '0);

      fill_table();
      random_phase(6);

      foreach (heap_plan[p]) begin
         wait_idle();
         write_heap_size(heap_plan[p]);
         random_phase(6);
      end

      wait_idle();
      if (fault_count == 0) begin
         $display("tb_mark_compact_bump_allocator_core passed");
      end else begin
         $display("tb_mark_compact_bump_allocator_core failed");
      end
      $finish;
   end

endmodule
